// File: design/gcl_pkg.sv
// Shared types and constants for the gradient colormap lookup.
package gcl_pkg;

  // Fixed field widths of the item channels and the register file
  localparam int unsigned IntensityWidth = 18;
  localparam int unsigned ChannelWidth   = 8;
  localparam int unsigned ArgbWidth      = 32;
  localparam int unsigned CountWidth     = 3;
  localparam int unsigned RegCount       = 8;
  localparam int unsigned PaddrWidth     = 5;
  localparam int unsigned PdataWidth     = 32;

  // Register indexes
  localparam logic [2:0] RegStopCount = 3'd0;
  localparam logic [2:0] RegColor0    = 3'd1;

  // What the output stage does with an item
  typedef enum logic [1:0] {
    KIND_INVALID,
    KIND_BLACK,
    KIND_MIX
  } kind_e;

endpackage

// File: design/gcl_if.sv
// Item channels: intensity in, ARGB colour out.
interface gcl_in_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [gcl_pkg::IntensityWidth-1:0]  intensity;
  logic                                       intensity_is_nan;

  modport source (output valid, output intensity, output intensity_is_nan, input ready);
  modport sink   (input valid, input intensity, input intensity_is_nan, output ready);
endinterface

interface gcl_out_if;
  logic                              valid;
  logic                              ready;
  logic                              color_valid;
  logic [gcl_pkg::ChannelWidth-1:0]  alpha;
  logic [gcl_pkg::ChannelWidth-1:0]  red;
  logic [gcl_pkg::ChannelWidth-1:0]  green;
  logic [gcl_pkg::ChannelWidth-1:0]  blue;

  modport source (output valid, output color_valid, output alpha, output red,
                  output green, output blue, input ready);
  modport sink   (input valid, input color_valid, input alpha, input red,
                  input green, input blue, output ready);
endinterface

// File: design/gradient_colormap_lookup_top.sv
// Gradient colormap lookup: intensity to ARGB through evenly spaced colour stops.
//
// Usage: program stop_count and color_0..color_6 over the APB port (register i
// at byte address 4*i) while no item is in flight. Items arrive on pix_i as a
// signed Q2.FRACTION_BITS intensity plus a not-a-number flag; each yields one
// colour item on col_o (color_valid, alpha, red, green, blue).
// Pipeline: an item accepted on pix_i passes through the input register, segment
// multiply, stop select and channel blend into the output register, from which
// it is shown on col_o. Throughput: one item per cycle while col_o is not stalled;
// the pipeline advances as a whole, so the channel blend multipliers and the
// segment multiply each see one item a cycle while it advances.
// When col_o is stalled with an item waiting, every stage holds and pix_i.ready
// drops in the same cycle; nothing is lost or repeated. When the output slot is
// empty or being taken, a new item enters while older ones move forward.
// Reset empties all stages and clears stop_count and all colours to zero, so
// every lookup is invalid until at least two stops are set.
module gradient_colormap_lookup_top #(
  parameter int unsigned MAX_STOPS     = 7,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [gcl_pkg::PaddrWidth-1:0]     paddr,
  input  logic [gcl_pkg::PdataWidth-1:0]     pwdata,
  output logic [gcl_pkg::PdataWidth-1:0]     prdata,
  output logic                               pready,
  gcl_in_if.sink                             pix_i,
  gcl_out_if.source                          col_o
);

  localparam int unsigned IntW   = gcl_pkg::IntensityWidth;
  localparam int unsigned RawW   = (IntW > FRACTION_BITS + 2) ? IntW : FRACTION_BITS + 2;
  localparam int unsigned SW     = RawW + gcl_pkg::CountWidth;
  localparam int unsigned SegW   = SW - FRACTION_BITS;
  localparam int unsigned FracW  = FRACTION_BITS + 1;
  localparam int unsigned MixW   = gcl_pkg::ChannelWidth + FracW + 1;
  localparam int unsigned CntW   = gcl_pkg::CountWidth;
  localparam int unsigned ChW    = gcl_pkg::ChannelWidth;

  localparam logic [RawW-1:0]  OneRaw  = RawW'(1) << FRACTION_BITS;
  localparam logic [FracW-1:0] OneFrac = FracW'(1) << FRACTION_BITS;
  localparam logic [CntW-1:0]  MaxCnt  = CntW'(MAX_STOPS);

  // ---------------------------------------------------------------- registers
  logic [CntW-1:0]                   count_q;
  logic [gcl_pkg::ArgbWidth-1:0]     color_q [MAX_STOPS];
  logic [2:0]                        reg_idx;
  logic                              cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[gcl_pkg::PaddrWidth-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int i = 0; i < MAX_STOPS; i++) begin
        color_q[i] <= '0;
      end
    end else if (cfg_wr) begin
      if (reg_idx == gcl_pkg::RegStopCount) begin
        count_q <= pwdata[CntW-1:0];
      end
      for (int i = 0; i < MAX_STOPS; i++) begin
        if (reg_idx == gcl_pkg::RegColor0 + 3'(i)) begin
          color_q[i] <= pwdata;
        end
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == gcl_pkg::RegStopCount) begin
      prdata = gcl_pkg::PdataWidth'(count_q);
    end
    for (int i = 0; i < MAX_STOPS; i++) begin
      if (reg_idx == gcl_pkg::RegColor0 + 3'(i)) begin
        prdata = color_q[i];
      end
    end
  end

  // ---------------------------------------------------------------- control
  logic adv;
  logic v1_q, v2_q, v3_q, vo_q;

  assign adv         = !vo_q || col_o.ready;
  assign pix_i.ready = adv;
  assign col_o.valid = vo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (adv) begin
      v1_q <= pix_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      vo_q <= v3_q;
    end
  end

  // ---------------------------------------------------------------- stage 1: capture
  logic [IntW-1:0] raw1_q;
  logic            nan1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      raw1_q <= pix_i.intensity;
      nan1_q <= pix_i.intensity_is_nan;
    end
  end

  // ---------------------------------------------------------------- stage 2: segment
  logic [CntW-1:0]   nsat;
  logic [CntW-1:0]   nm1;
  logic [CntW-1:0]   nm2;
  logic [RawW-1:0]   raw_ext;
  logic [SW-1:0]     s_prod;
  logic [SegW-1:0]   seg_raw;
  logic              seg_clamp;
  gcl_pkg::kind_e    kind2_d;
  logic [CntW-1:0]   seg2_d;
  logic [FracW-1:0]  frac2_d;

  gcl_pkg::kind_e    kind2_q;
  logic [CntW-1:0]   seg2_q;
  logic [FracW-1:0]  frac2_q;

  assign nsat      = (count_q > MaxCnt) ? MaxCnt : count_q;
  assign nm1       = nsat - CntW'(1);
  assign nm2       = nsat - CntW'(2);
  assign raw_ext   = RawW'(raw1_q);
  assign s_prod    = SW'(raw_ext) * SW'(nm1);
  assign seg_raw   = s_prod[SW-1:FRACTION_BITS];
  assign seg_clamp = seg_raw > SegW'(nm2);

  always_comb begin
    if (nsat < CntW'(2)) begin
      kind2_d = gcl_pkg::KIND_INVALID;
    end else if (nan1_q) begin
      kind2_d = gcl_pkg::KIND_BLACK;
    end else if (raw1_q[IntW-1] || raw_ext > OneRaw) begin
      kind2_d = gcl_pkg::KIND_INVALID;
    end else begin
      kind2_d = gcl_pkg::KIND_MIX;
    end
    // Only intensity 1.0 lands past the last segment: use it with a full fraction
    if (seg_clamp) begin
      seg2_d  = nm2;
      frac2_d = OneFrac;
    end else begin
      seg2_d  = seg_raw[CntW-1:0];
      frac2_d = {1'b0, s_prod[FRACTION_BITS-1:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      kind2_q <= kind2_d;
      seg2_q  <= seg2_d;
      frac2_q <= frac2_d;
    end
  end

  // ---------------------------------------------------------------- stage 3: stop select
  logic [CntW-1:0]               seg_hi;
  logic [gcl_pkg::ArgbWidth-1:0] lo3_d, hi3_d;
  logic [gcl_pkg::ArgbWidth-1:0] lo3_q, hi3_q;
  gcl_pkg::kind_e                kind3_q;
  logic [FracW-1:0]              frac3_q;

  assign seg_hi = seg2_q + CntW'(1);

  always_comb begin
    lo3_d = '0;
    hi3_d = '0;
    for (int i = 0; i < MAX_STOPS; i++) begin
      lo3_d = lo3_d | (color_q[i] & {gcl_pkg::ArgbWidth{seg2_q == CntW'(i)}});
      hi3_d = hi3_d | (color_q[i] & {gcl_pkg::ArgbWidth{seg_hi == CntW'(i)}});
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lo3_q   <= lo3_d;
      hi3_q   <= hi3_d;
      kind3_q <= kind2_q;
      frac3_q <= frac2_q;
    end
  end

  // ---------------------------------------------------------------- stage 4: blend
  logic [FracW-1:0] frac_inv;
  logic [MixW-1:0]  mix [4];
  logic [ChW-1:0]   blend [4];
  logic             cv_d;
  logic [ChW-1:0]   ch_d [4];
  logic             cv_q;
  logic [ChW-1:0]   ch_q [4];

  assign frac_inv = OneFrac - frac3_q;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      mix[k] = MixW'(lo3_q[gcl_pkg::ArgbWidth-1-ChW*k -: ChW]) * MixW'(frac_inv)
             + MixW'(hi3_q[gcl_pkg::ArgbWidth-1-ChW*k -: ChW]) * MixW'(frac3_q);
      blend[k] = mix[k][FRACTION_BITS +: ChW];
    end
  end

  always_comb begin
    cv_d = 1'b0;
    for (int k = 0; k < 4; k++) begin
      ch_d[k] = '0;
    end
    case (kind3_q)
      gcl_pkg::KIND_BLACK: begin
        cv_d    = 1'b1;
        ch_d[0] = '1;
      end
      gcl_pkg::KIND_MIX: begin
        cv_d = 1'b1;
        for (int k = 0; k < 4; k++) begin
          ch_d[k] = blend[k];
        end
      end
      default: begin
        cv_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cv_q <= cv_d;
      for (int k = 0; k < 4; k++) begin
        ch_q[k] <= ch_d[k];
      end
    end
  end

  assign col_o.color_valid = cv_q;
  assign col_o.alpha       = ch_q[0];
  assign col_o.red         = ch_q[1];
  assign col_o.green       = ch_q[2];
  assign col_o.blue        = ch_q[3];

endmodule

// File: tb/tb_gradient_colormap_lookup_top.sv
// Self-checking testbench for the gradient colormap lookup top level.
`timescale 1ns / 1ps

module tb_gradient_colormap_lookup_top;

  localparam int unsigned MaxStops     = 7;
  localparam int unsigned FractionBits = 16;
  localparam int          One          = 1 << FractionBits;
  localparam int unsigned MaxWait      = 18;
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned DrainCycles  = 8;

  localparam int unsigned IntensityWidth = gcl_pkg::IntensityWidth;
  localparam int unsigned ChannelWidth   = gcl_pkg::ChannelWidth;
  localparam int unsigned ArgbWidth      = gcl_pkg::ArgbWidth;
  localparam int unsigned CountWidth     = gcl_pkg::CountWidth;
  localparam int unsigned PaddrWidth     = gcl_pkg::PaddrWidth;
  localparam int unsigned PdataWidth     = gcl_pkg::PdataWidth;
  localparam int unsigned RegStopCount   = 32'(gcl_pkg::RegStopCount);
  localparam int unsigned RegColor0      = 32'(gcl_pkg::RegColor0);

  typedef struct packed {
    logic                    color_valid;
    logic [ChannelWidth-1:0] alpha;
    logic [ChannelWidth-1:0] red;
    logic [ChannelWidth-1:0] green;
    logic [ChannelWidth-1:0] blue;
  } argb_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PaddrWidth-1:0] paddr;
  logic [PdataWidth-1:0] pwdata;
  logic [PdataWidth-1:0] prdata;
  logic                  pready;

  gcl_in_if  pix_if ();
  gcl_out_if col_if ();

  gradient_colormap_lookup_top #(
    .MAX_STOPS     (MaxStops),
    .FRACTION_BITS (FractionBits)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pix_i   (pix_if),
    .col_o   (col_if)
  );

  always #6 clk_i = ~clk_i;

  // Shadow of the register file, updated on every APB write
  logic [CountWidth-1:0] stops_cfg;
  logic [ArgbWidth-1:0]  stop_colors [MaxStops];
  logic [ArgbWidth-1:0]  planned_colors [MaxStops];

  argb_result_t expected_colors [$];
  int unsigned  mismatch_count;
  bit           sender_idles;
  bit           receiver_idles;

  function automatic int unsigned draw_wait(input bit enabled);
    return enabled ? $urandom_range(0, MaxWait) : 0;
  endfunction

  function automatic argb_result_t predict_color(input logic signed [IntensityWidth-1:0] value,
                                                 input logic is_nan);
    argb_result_t        res;
    gcl_pkg::kind_e      kind;
    int unsigned         n;
    int unsigned         span;
    int unsigned         seg;
    int unsigned         frac;
    int unsigned         k;
    longint unsigned     mix;
    logic [ArgbWidth-1:0] lo;
    logic [ArgbWidth-1:0] hi;
    logic [ArgbWidth-1:0] mixed;
    res = '0;
    n   = 32'(stops_cfg);
    if (n > MaxStops) n = MaxStops;
    if (n < 2) kind = gcl_pkg::KIND_INVALID;
    else if (is_nan) kind = gcl_pkg::KIND_BLACK;
    else if (int'(value) < 0 || int'(value) > One) kind = gcl_pkg::KIND_INVALID;
    else kind = gcl_pkg::KIND_MIX;
    case (kind)
      gcl_pkg::KIND_BLACK: begin
        res.color_valid = 1'b1;
        res.alpha       = '1;
      end
      gcl_pkg::KIND_MIX: begin
        span = int'(value) * (n - 1);
        seg  = span >> FractionBits;
        // intensity 1.0 stays in the last segment with a full fraction
        if (seg > n - 2) seg = n - 2;
        frac = span - seg * One;
        lo   = stop_colors[seg];
        hi   = stop_colors[seg + 1];
        for (k = 0; k < 4; k++) begin
          mix = longint'(lo[8*k +: 8]) * (One - frac) + longint'(hi[8*k +: 8]) * frac;
          mixed[8*k +: 8] = mix[FractionBits +: 8];
        end
        res.color_valid = 1'b1;
        {res.alpha, res.red, res.green, res.blue} = mixed;
      end
      default: res = '0;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < 100)
      $display("%0t: %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Compare every accepted color item with the oldest prediction
  always @(posedge clk_i) begin
    argb_result_t want;
    if (rst_ni && col_if.valid && col_if.ready) begin
      if (expected_colors.size() == 0) begin
        report_mismatch("unexpected color item", int'(col_if.color_valid), 0);
      end else begin
        want = expected_colors.pop_front();
        if (col_if.color_valid !== want.color_valid)
          report_mismatch("color_valid", int'(col_if.color_valid), int'(want.color_valid));
        if (col_if.alpha !== want.alpha)
          report_mismatch("alpha", int'(col_if.alpha), int'(want.alpha));
        if (col_if.red !== want.red)
          report_mismatch("red", int'(col_if.red), int'(want.red));
        if (col_if.green !== want.green)
          report_mismatch("green", int'(col_if.green), int'(want.green));
        if (col_if.blue !== want.blue)
          report_mismatch("blue", int'(col_if.blue), int'(want.blue));
      end
    end
  end

  // Color sink: when receiver_idles is set, stall a random number of cycles before each item
  initial begin
    int unsigned stall;
    col_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = draw_wait(receiver_idles);
      if (stall > 0) begin
        col_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      col_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(col_if.valid && col_if.ready));
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((pix_if.valid && pix_if.ready) || (col_if.valid && col_if.ready) || (psel && penable))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("gradient_colormap_lookup_top: mismatch");
    $finish;
  end

  task automatic send_intensity(input logic signed [IntensityWidth-1:0] value,
                                input logic is_nan);
    int unsigned gap;
    gap = draw_wait(sender_idles);
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_if.valid            <= 1'b1;
    pix_if.intensity        <= value;
    pix_if.intensity_is_nan <= is_nan;
    do @(posedge clk_i); while (!(pix_if.valid && pix_if.ready));
    expected_colors.push_back(predict_color(value, is_nan));
  endtask

  // Mostly in-range positions, some on segment edges, some NaN, the rest anywhere
  task automatic send_random_item();
    int unsigned segs;
    int unsigned pick;
    int          pos;
    segs = (stops_cfg < 2) ? 1 : 32'(stops_cfg) - 1;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      send_intensity(IntensityWidth'($urandom_range(0, One)), 1'b0);
    end else if (pick < 78) begin
      pos = ($urandom_range(0, segs) * One) / segs + $urandom_range(0, 2) - 1;
      send_intensity(IntensityWidth'(pos), 1'b0);
    end else if (pick < 86) begin
      send_intensity(IntensityWidth'($urandom), 1'b1);
    end else begin
      send_intensity(IntensityWidth'($urandom), 1'($urandom_range(0, 1)));
    end
  endtask

  // Hold psel across back-to-back writes; apb_release drops it
  task automatic write_reg(input int unsigned index, input logic [PdataWidth-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PaddrWidth'(index << 2);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (index == RegStopCount) stops_cfg = value[CountWidth-1:0];
    else stop_colors[index - RegColor0] = value;
  endtask

  task automatic apb_release();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_drained();
    pix_if.valid <= 1'b0;
    do @(posedge clk_i); while (expected_colors.size() != 0);
  endtask

  task automatic program_gradient(input int unsigned count);
    int unsigned i;
    wait_drained();
    // upper bits of the count write are don't-care
    write_reg(RegStopCount, {$urandom} & ~PdataWidth'(7) | PdataWidth'(count));
    for (i = 0; i < MaxStops; i++) write_reg(RegColor0 + i, planned_colors[i]);
    apb_release();
  endtask

  function automatic logic [ArgbWidth-1:0] pick_color();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_reset_state();
    send_intensity(IntensityWidth'(0), 1'b0);
    send_intensity(IntensityWidth'(One / 2), 1'b0);
    send_intensity(IntensityWidth'(One / 2), 1'b1);
  endtask

  task automatic test_single_stop();
    wait_drained();
    write_reg(RegStopCount, PdataWidth'(1));
    apb_release();
    send_intensity(IntensityWidth'(One), 1'b0);
    send_intensity(IntensityWidth'(0), 1'b1);
  endtask

  task automatic test_two_stop_edges();
    int unsigned i;
    planned_colors[0] = 32'hFF00_FF00;
    planned_colors[1] = 32'h00FF_00FF;
    for (i = 2; i < MaxStops; i++) planned_colors[i] = pick_color();
    program_gradient(2);
    send_intensity(IntensityWidth'(0), 1'b0);
    send_intensity(IntensityWidth'(One), 1'b0);
    send_intensity(IntensityWidth'(One / 2), 1'b0);
    send_intensity(IntensityWidth'(One - 1), 1'b0);
    send_intensity(IntensityWidth'(1), 1'b0);
    send_intensity(IntensityWidth'(One + 1), 1'b0);
    send_intensity(IntensityWidth'(-1), 1'b0);
    send_intensity(IntensityWidth'(-131072), 1'b0);
    send_intensity(IntensityWidth'(131071), 1'b0);
    send_intensity(IntensityWidth'(12345), 1'b1);
    send_intensity(IntensityWidth'(-131072), 1'b1);
  endtask

  task automatic test_segment_boundaries();
    int unsigned marks [8] = '{10922, 10923, 21845, 21846, 32768, 43691, 54613, 65536};
    int unsigned i;
    for (i = 0; i < MaxStops; i++) planned_colors[i] = $urandom;
    program_gradient(MaxStops);
    for (i = 0; i < 8; i++) send_intensity(IntensityWidth'(marks[i]), 1'b0);
  endtask

  task automatic test_random_gradients();
    int unsigned counts [12] = '{7, 2, 3, 4, 5, 6, 7, 1, 0, 3, 5, 2};
    int unsigned p;
    int unsigned i;
    for (p = 0; p < 12; p++) begin
      sender_idles   = p[0];
      receiver_idles = p[1];
      for (i = 0; i < MaxStops; i++)
        planned_colors[i] = (p == 1) ? (i[0] ? 32'hFFFF_FFFF : 32'h0) : pick_color();
      program_gradient(counts[p]);
      repeat (counts[p] < 2 ? 30 : 85) send_random_item();
    end
  endtask

  // Let the block run dry between bursts while the sink keeps stalling
  task automatic test_drain_pause();
    int unsigned i;
    sender_idles   = 1'b0;
    receiver_idles = 1'b1;
    for (i = 0; i < MaxStops; i++) planned_colors[i] = pick_color();
    program_gradient(6);
    repeat (5) begin
      repeat (30) send_random_item();
      wait_drained();
    end
  endtask

  initial begin
    rst_ni                   = 1'b0;
    psel                     = 1'b0;
    penable                  = 1'b0;
    pwrite                   = 1'b0;
    paddr                    = '0;
    pwdata                   = '0;
    pix_if.valid             = 1'b0;
    pix_if.intensity         = '0;
    pix_if.intensity_is_nan  = 1'b0;
    stops_cfg                = '0;
    foreach (stop_colors[i]) stop_colors[i] = '0;
    mismatch_count           = 0;
    sender_idles             = 1'b0;
    receiver_idles           = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_single_stop();
    test_two_stop_edges();
    test_segment_boundaries();
    test_random_gradients();
    test_drain_pause();

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("gradient_colormap_lookup_top: match");
    end else begin
      $display("gradient_colormap_lookup_top: mismatch");
    end
    $finish;
  end

endmodule
